// ===== sv/fdlm_pkg.sv =====
//==============================================================================
// fdlm_pkg: shared types and constants for the deformation local matrix core
// Holds command codes, register indexes and fixed point saturation limits.
//==============================================================================
`default_nettype none

package fdlm_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_ACCUM = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_DIMENSION   = 2'd0;
  localparam logic [1:0] REG_BASIS_COUNT = 2'd1;
  localparam logic [1:0] REG_VISCOSITY   = 2'd2;

  localparam logic signed [47:0] SAT_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] SAT_MIN = {1'b1, {47{1'b0}}};

  localparam int NUM_BLOCKS = 9;

endpackage

`default_nettype wire

// ===== sv/fem_deformation_local_matrix_core.sv =====
//==============================================================================
// fem_deformation_local_matrix_core: symmetric-gradient viscous local matrices
// Keeps basis gradients and nine local matrices, accumulates one quadrature
// point per accumulate command through one shared multiplier.
//==============================================================================
// Each command is answered with one result on out_valid. Accumulate works
// through every (i,j) pair of the n basis functions, all products passing
// through the single multiplier.
// Items are taken one at a time; a new item waits until the last result is taken.
// Reset: control and overflow flag cleared, configuration registers set to
// defaults; a clearing pass then zeroes the matrix memory before items are taken.
`default_nettype none

module fem_deformation_local_matrix_core
  import fdlm_pkg::*;
#(
  parameter int MAX_BASIS = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  command,
  input  wire  [4:0]  row_index,
  input  wire  [4:0]  column_index,
  input  wire  [3:0]  block_select,
  input  wire  [31:0] grad_x,
  input  wire  [31:0] grad_y,
  input  wire  [31:0] grad_z,
  input  wire  [31:0] weight,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [47:0] entry_value,
  output logic        overflow
);

  localparam int IW = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;
  localparam int DEPTH = NUM_BLOCKS * MAX_BASIS * MAX_BASIS;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(MAX_BASIS + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_C0, S_C1, S_PROD, S_PRODW, S_TERM, S_SCALE, S_SCALEW,
    S_RD, S_ADD, S_NEXT, S_RREAD, S_RWAIT, S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [1:0]  dimension;
  logic [5:0]  basis_count;
  logic [31:0] viscosity;

  // Gradient store (undefined until written) and matrix memory.
  logic [95:0] gstore [MAX_BASIS];
  logic signed [47:0] mem [DEPTH];
  logic [AW-1:0] maddr;
  logic signed [47:0] mrdata;
  logic mwe;
  logic signed [47:0] mwdata;

  logic [IW-1:0] ii, jj;
  logic [CW-1:0] n;
  logic [3:0] pidx;              // product index r*3+q
  logic [3:0] blk;
  logic [31:0] weight_q;         // quadrature weight held for the accumulate
  logic clr_pending;             // clear pass started by a clear command
  logic signed [63:0] cprod;     // weight*nu, Q.32
  logic signed [47:0] pr [9];    // rounded gradient products Q.16
  logic signed [49:0] sterm;
  logic signed [47:0] term;
  logic [1:0] slice;             // partial product step for c*s
  logic signed [113:0] acc;
  logic [95:0] gi, gj;
  logic two_d;
  logic [AW-1:0] clr_addr;
  logic [1:0] crow;              // which c half
  logic signed [47:0] result;

  // Shared multiplier.
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;

  fdlm_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  assign cfg_ready = (state == S_IDLE) || (state == S_CLEAR);
  assign in_stall  = (state != S_IDLE) || out_valid;
  assign two_d     = (dimension == 2'd2);
  assign gi        = gstore[ii];
  assign gj        = gstore[jj];

  // Round a product half away from zero to Q.16.
  function automatic logic signed [47:0] rnd16(input logic signed [65:0] p);
    logic [65:0] m;
    logic [65:0] r;
    begin
      m = p[65] ? -p : p;
      r = (m + 66'd32768) >> 16;
      rnd16 = p[65] ? -r[47:0] : r[47:0];
    end
  endfunction

  // Block term from rounded products for block b.
  always_comb begin
    case (blk)
      4'd0: sterm = 50'(pr[0]) * 2 + 50'(pr[4]) + 50'(pr[8]);
      4'd1: sterm = 50'(pr[3]);
      4'd2: sterm = 50'(pr[6]);
      4'd3: sterm = 50'(pr[1]);
      4'd4: sterm = 50'(pr[0]) + 50'(pr[4]) * 2 + 50'(pr[8]);
      4'd5: sterm = 50'(pr[7]);
      4'd6: sterm = 50'(pr[2]);
      4'd7: sterm = 50'(pr[5]);
      default: sterm = 50'(pr[0]) + 50'(pr[4]) + 50'(pr[8]) * 2;
    endcase
  end

  // Multiplier operand selection.
  logic [1:0] rsel, qsel;
  logic signed [31:0] ga, gb;
  logic [49:0] smag;
  logic [63:0] cmag;
  assign rsel = (pidx >= 4'd6) ? 2'd2 : (pidx >= 4'd3) ? 2'd1 : 2'd0;
  assign qsel = 2'(pidx - 4'(rsel) * 4'd3);
  assign ga = gi[32*rsel +: 32];
  assign gb = gj[32*qsel +: 32];
  assign smag = sterm[49] ? -sterm : sterm;
  assign cmag = cprod[63] ? -cprod : cprod;

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_C0: begin
        ma = 33'(signed'(weight_q));
        mb = 33'(signed'(viscosity));
      end
      S_PROD: begin
        ma = 33'(ga);
        mb = 33'(gb);
      end
      S_SCALE: begin
        // Unsigned 32x32 partial products of |c| and |s|.
        ma = {1'b0, crow[0] ? cmag[63:32] : cmag[31:0]};
        mb = slice[0] ? {1'b0, 14'd0, smag[49:32]} : {1'b0, smag[31:0]};
      end
      default: begin
      end
    endcase
  end

  // Saturation of the scaled magnitude and of the sum.
  logic [113:0] nacc;
  logic [81:0] qm;
  logic neg;
  logic signed [48:0] sum;
  assign nacc = acc + 114'h80000000;
  assign qm   = nacc[113:32];
  assign neg  = cprod[63] ^ sterm[49];

  logic signed [47:0] tsat;
  logic tovf;
  always_comb begin
    tovf = 1'b0;
    tsat = neg ? -48'(qm) : 48'(qm);
    if (neg && qm > 82'h800000000000) begin
      tovf = 1'b1;
      tsat = SAT_MIN;
    end else if (!neg && qm > 82'h7FFFFFFFFFFF) begin
      tovf = 1'b1;
      tsat = SAT_MAX;
    end
  end

  assign sum = 49'(mrdata) + 49'(term);

  // Memory port.
  always_ff @(posedge clk) begin
    if (mwe) mem[maddr] <= mwdata;
    mrdata <= mem[maddr];
  end

  // Address of the current entry.
  function automatic logic [AW-1:0] addr_of(input logic [3:0] b, input logic [IW-1:0] r,
                                            input logic [IW-1:0] c);
    addr_of = AW'((32'(b) * MAX_BASIS + 32'(r)) * MAX_BASIS + 32'(c));
  endfunction

  always_comb begin
    mwe = 1'b0;
    mwdata = '0;
    maddr = addr_of(blk, ii, jj);
    if (state == S_CLEAR) begin
      mwe = 1'b1;
      maddr = clr_addr;
    end else if (state == S_ADD) begin
      mwe = 1'b1;
      if (sum > 49'(SAT_MAX)) mwdata = SAT_MAX;
      else if (sum < 49'(SAT_MIN)) mwdata = SAT_MIN;
      else mwdata = sum[47:0];
    end
  end

  // Next block in the sequence for the current dimension.
  function automatic logic [3:0] next_blk(input logic [3:0] b, input logic d2);
    if (d2) next_blk = (b == 4'd0) ? 4'd1 : (b == 4'd1) ? 4'd3 : (b == 4'd3) ? 4'd4 : 4'd15;
    else next_blk = (b == 4'd8) ? 4'd15 : b + 4'd1;
  endfunction

  // Sequencer and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      clr_pending <= 1'b0;
      dimension <= 2'd3;
      basis_count <= 6'd32;
      viscosity <= 32'd65536;
      overflow <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DIMENSION:   dimension <= cfg_data[1:0];
          REG_BASIS_COUNT: basis_count <= cfg_data[5:0];
          REG_VISCOSITY:   viscosity <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == DEPTH - 1) begin
            // A clear command answers with one result; the reset pass does not.
            state <= clr_pending ? S_OUT : S_IDLE;
            clr_pending <= 1'b0;
            result <= '0;
          end
        end
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            result <= '0;
            case (cmd_t'(command))
              CMD_LOAD: begin
                if (32'(row_index) < MAX_BASIS)
                  gstore[IW'(row_index)] <= {grad_z, grad_y, grad_x};
                state <= S_OUT;
              end
              CMD_ACCUM: begin
                n <= (32'(basis_count) > MAX_BASIS) ? CW'(MAX_BASIS) : CW'(basis_count);
                weight_q <= weight;
                state <= S_C0;
              end
              CMD_CLEAR: begin
                overflow <= 1'b0;
                clr_addr <= '0;
                clr_pending <= 1'b1;
                state <= S_CLEAR;
              end
              default: begin
                if (block_select < 4'd9 && 32'(row_index) < MAX_BASIS &&
                    32'(column_index) < MAX_BASIS) begin
                  blk <= block_select;
                  ii <= IW'(row_index);
                  jj <= IW'(column_index);
                  state <= S_RREAD;
                end else begin
                  state <= S_OUT;
                end
              end
            endcase
          end
        end
        S_C0: begin
          ii <= '0;
          jj <= '0;
          state <= S_C1;
        end
        S_C1: begin
          cprod <= mp[63:0];
          if (n == '0) state <= S_OUT;
          else begin
            pidx <= '0;
            state <= S_PROD;
          end
        end
        S_PROD: state <= S_PRODW;
        S_PRODW: begin
          pr[pidx] <= (two_d && (rsel == 2'd2 || qsel == 2'd2)) ? '0 : rnd16(mp);
          if (pidx == 4'd8) begin
            blk <= '0;
            state <= S_TERM;
          end else begin
            pidx <= pidx + 4'd1;
            state <= S_PROD;
          end
        end
        S_TERM: begin
          acc <= '0;
          slice <= '0;
          crow <= '0;
          state <= S_SCALE;
        end
        S_SCALE: state <= S_SCALEW;
        S_SCALEW: begin
          // Sum partial products: crow selects c half, slice[0] the s half.
          acc <= acc + (114'(mp[63:0]) << (32 * (32'(crow) + 32'(slice[0]))));
          if (slice == 2'd1 && crow == 2'd1) state <= S_RD;
          else begin
            if (slice == 2'd1) begin
              slice <= '0;
              crow <= crow + 2'd1;
            end else slice <= 2'd1;
            state <= S_SCALE;
          end
        end
        S_RD: begin
          term <= tsat;
          if (tovf) overflow <= 1'b1;
          state <= S_ADD;
        end
        S_ADD: begin
          if (sum > 49'(SAT_MAX) || sum < 49'(SAT_MIN)) overflow <= 1'b1;
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (next_blk(blk, two_d) != 4'd15) begin
            blk <= next_blk(blk, two_d);
            state <= S_TERM;
          end else if (32'(jj) + 1 < 32'(n)) begin
            jj <= jj + 1'b1;
            pidx <= '0;
            state <= S_PROD;
          end else if (32'(ii) + 1 < 32'(n)) begin
            ii <= ii + 1'b1;
            jj <= '0;
            pidx <= '0;
            state <= S_PROD;
          end else state <= S_OUT;
        end
        S_RREAD: state <= S_RWAIT;
        S_RWAIT: begin
          result <= mrdata;
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign entry_value = result;

  // Checks on sequencing.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("item accepted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_clear_flag: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && command == CMD_CLEAR) |=> !overflow)
    else $error("overflow not cleared");

endmodule

`default_nettype wire

// ===== sv/fdlm_mul.sv =====
//==============================================================================
// fdlm_mul: registered signed multiplier
// One 33 x 33 signed product per cycle, result registered.
//==============================================================================
`default_nettype none

module fdlm_mul
  import fdlm_pkg::*;
(
  input  wire               clk,
  input  wire signed [32:0] a,
  input  wire signed [32:0] b,
  output logic signed [65:0] p
);

  // Product register feeding the sequencer.
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire
